// ----- design/lcp_pkg.sv -----
// ----------------------------------------------------------------------------
// lcp_pkg
// Shared constants for the cursor linked list pool: field widths, operation
// codes, status codes and the default sizes of the node pool and list table.
// ----------------------------------------------------------------------------
`default_nettype none

package lcp_pkg;

  // Default sizes
  localparam int NODE_COUNT_DEF = 256;
  localparam int LIST_COUNT_DEF = 16;
  localparam int ITEM_BITS_DEF  = 32;

  // Field widths on the stream ports
  localparam int OP_W      = 3;
  localparam int ID_W      = 4;
  localparam int VAL_W     = 32;
  localparam int ST_W      = 3;
  localparam int NODE_W    = 8;
  localparam int CNT_W     = 9;
  localparam int OFF_W     = 8;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;

  // Operation codes
  localparam logic [OP_W-1:0] OP_CREATE  = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD     = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT  = 3'd2;
  localparam logic [OP_W-1:0] OP_APPEND  = 3'd3;
  localparam logic [OP_W-1:0] OP_PREPEND = 3'd4;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK         = 3'd0;
  localparam logic [ST_W-1:0] ST_BAD_ITEM   = 3'd1;
  localparam logic [ST_W-1:0] ST_POOL_FULL  = 3'd2;
  localparam logic [ST_W-1:0] ST_TABLE_FULL = 3'd3;
  localparam logic [ST_W-1:0] ST_NO_LIST    = 3'd4;

  typedef struct packed {
    logic [OFF_W-1:0]  cursor_offset;
    logic [CNT_W-1:0]  item_count;
    logic [NODE_W-1:0] node_index;
    logic [ID_W-1:0]   created_list;
    logic [ST_W-1:0]   status;
  } result_t;

endpackage

`default_nettype wire

// ----- design/lcp_ram.sv -----
// ----------------------------------------------------------------------------
// lcp_ram
// Generic single write port, single read port RAM with registered read data.
// Read data holds while no read is requested.
// ----------------------------------------------------------------------------
`default_nettype none

module lcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                           wr_data,
  input  wire logic                                       rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- design/cursor_linked_list_pool.sv -----
// ----------------------------------------------------------------------------
// cursor_linked_list_pool
// Several doubly linked lists with cursors over one shared, never freed node
// pool. Operations: create list, add after cursor, insert before cursor,
// append, prepend.
// ----------------------------------------------------------------------------
// One transaction is taken at a time. A create or a rejected operation
// goes through the list table read and registers its result as it
// returns to idle; a successful insert goes through the list table read,
// neighbour link read (add and insert only), new node write and neighbour
// link write, paced by the single write port of each link RAM, and
// registers its result with the neighbour link write. A result still
// waiting on the output register stalls that last step. Unknown opcodes are
// consumed on acceptance and give no result. The next transaction is
// accepted once the block is back in idle, even while a result still waits
// on the output register. Link, item and list table storage sits in RAMs
// whose contents are undefined until written; nothing needs clearing after
// reset.
// ----------------------------------------------------------------------------
`default_nettype none

module cursor_linked_list_pool #(
  parameter int NODE_COUNT = lcp_pkg::NODE_COUNT_DEF,
  parameter int LIST_COUNT = lcp_pkg::LIST_COUNT_DEF,
  parameter int ITEM_BITS  = lcp_pkg::ITEM_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // opcode[2:0], list_id[6:3], item_value[38:7], zero pad[39]
  input  wire logic [lcp_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // status[2:0], created_list[6:3], node_index[14:7], item_count[23:15],
  // cursor_offset[31:24]
  output logic      [lcp_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready
);

  import lcp_pkg::*;

  localparam int NW  = $clog2(NODE_COUNT);          // node address
  localparam int LW  = $clog2(NODE_COUNT + 1);      // link, may hold "none"
  localparam int LUW = $clog2(LIST_COUNT + 1);
  localparam int LAW = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
  localparam logic [LW-1:0] NO_NODE = LW'(NODE_COUNT);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LIST = 2'd1;
  localparam logic [1:0] S_LINK = 2'd2;
  localparam logic [1:0] S_NBR  = 2'd3;

  typedef struct packed {
    logic [LW-1:0] head;
    logic [LW-1:0] tail;
    logic [LW-1:0] cursor;
    logic [LW-1:0] count;
    logic [NW-1:0] offset;
  } list_ent_t;

  logic [1:0]           state_r, state_nxt;
  logic [OP_W-1:0]      op_r;
  logic [ID_W-1:0]      id_r;
  logic [ITEM_BITS-1:0] item_r;
  list_ent_t            ent_r, ent_nxt;
  list_ent_t            upd_r, upd_nxt;
  logic                 empty_r, empty_nxt;
  logic [LW-1:0]        nb_r, nb_nxt;
  logic [LW-1:0]        nodes_used_r, nodes_used_nxt;
  logic [LUW-1:0]       lists_used_r, lists_used_nxt;
  logic                 out_valid_r, out_valid_nxt;
  result_t              res_r, res_nxt;

  logic                 in_fire, out_free, res_fire;
  logic [OP_W-1:0]      in_op;
  logic [NW-1:0]        new_node;

  list_ent_t            list_q, list_wd;
  logic                 list_we, list_re;
  logic [LAW-1:0]       list_wa;

  logic [LW-1:0]        next_q, prev_q, next_wd, prev_wd;
  logic                 next_we, prev_we, next_re, prev_re;
  logic [NW-1:0]        next_wa, prev_wa;
  logic                 item_we;

  logic                 real_nb;

  assign in_op     = in_tdata[2:0];
  // hold off input while reset is asserted
  assign in_tready = rst_n & (state_r == S_IDLE);
  assign in_fire   = in_tvalid & in_tready;
  assign out_free  = ~out_valid_r | out_tready;
  assign new_node  = NW'(nodes_used_r);
  assign real_nb   = (nb_r < NO_NODE);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r;

  always_comb begin
    state_nxt      = state_r;
    ent_nxt        = ent_r;
    upd_nxt        = upd_r;
    empty_nxt      = empty_r;
    nb_nxt         = nb_r;
    nodes_used_nxt = nodes_used_r;
    lists_used_nxt = lists_used_r;
    res_nxt        = res_r;
    res_fire       = 1'b0;
    list_re        = 1'b0;
    list_we        = 1'b0;
    list_wa        = LAW'(id_r);
    list_wd        = upd_nxt;
    next_re        = 1'b0;
    prev_re        = 1'b0;
    next_we        = 1'b0;
    prev_we        = 1'b0;
    next_wa        = new_node;
    prev_wa        = new_node;
    next_wd        = NO_NODE;
    prev_wd        = NO_NODE;
    item_we        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          // unknown opcodes are dropped here
          if (in_op <= OP_PREPEND) begin
            list_re   = 1'b1;
            state_nxt = S_LIST;
          end
        end
      end

      S_LIST: begin
        res_nxt = '0;
        if (op_r == OP_CREATE) begin
          if (out_free) begin
            res_fire  = 1'b1;
            state_nxt = S_IDLE;
            if (lists_used_r == LUW'(LIST_COUNT)) begin
              res_nxt.status = ST_TABLE_FULL;
            end else begin
              list_we        = 1'b1;
              list_wa        = LAW'(lists_used_r);
              list_wd        = '{head: NO_NODE, tail: NO_NODE, cursor: NO_NODE,
                                 count: '0, offset: '0};
              lists_used_nxt = lists_used_r + 1'b1;
              res_nxt.status       = ST_OK;
              res_nxt.created_list = ID_W'(lists_used_r);
            end
          end
        end else if (32'(id_r) >= 32'(lists_used_r) || item_r == '0 ||
                     nodes_used_r == NO_NODE) begin
          if (out_free) begin
            res_fire  = 1'b1;
            state_nxt = S_IDLE;
            if (32'(id_r) >= 32'(lists_used_r)) begin
              res_nxt.status = ST_NO_LIST;
            end else if (item_r == '0) begin
              res_nxt.status = ST_BAD_ITEM;
            end else begin
              res_nxt.status = ST_POOL_FULL;
            end
          end
        end else begin
          ent_nxt   = list_q;
          empty_nxt = (list_q.count == '0) || !(list_q.cursor < NO_NODE);
          item_we   = 1'b1;
          // fetch the cursor's neighbour in the direction of the insert
          next_re   = (op_r == OP_ADD);
          prev_re   = (op_r == OP_INSERT);
          state_nxt = S_LINK;
        end
      end

      S_LINK: begin
        case (op_r)
          OP_ADD:    nb_nxt = next_q;
          OP_INSERT: nb_nxt = prev_q;
          OP_APPEND: nb_nxt = ent_r.tail;
          default:   nb_nxt = ent_r.head;
        endcase
        if (empty_r) begin
          nb_nxt = NO_NODE;
        end

        upd_nxt        = ent_r;
        upd_nxt.cursor = LW'(new_node);
        if (empty_r) begin
          upd_nxt.head   = LW'(new_node);
          upd_nxt.tail   = LW'(new_node);
          upd_nxt.count  = LW'(1);
          upd_nxt.offset = '0;
        end else begin
          upd_nxt.count = ent_r.count + 1'b1;
          case (op_r)
            OP_ADD: begin
              upd_nxt.offset = ent_r.offset + 1'b1;
              if (!(nb_nxt < NO_NODE)) begin
                upd_nxt.tail = LW'(new_node);
              end
            end
            OP_INSERT: begin
              if (!(nb_nxt < NO_NODE)) begin
                upd_nxt.head = LW'(new_node);
              end
            end
            OP_APPEND: begin
              upd_nxt.tail   = LW'(new_node);
              upd_nxt.offset = NW'(ent_r.count);
            end
            default: begin
              upd_nxt.head   = LW'(new_node);
              upd_nxt.offset = '0;
            end
          endcase
        end

        list_we = 1'b1;
        list_wa = LAW'(id_r);
        list_wd = upd_nxt;

        // links of the new node
        next_we = 1'b1;
        prev_we = 1'b1;
        if (!empty_r) begin
          case (op_r)
            OP_ADD: begin
              prev_wd = ent_r.cursor;
              next_wd = nb_nxt;
            end
            OP_INSERT: begin
              next_wd = ent_r.cursor;
              prev_wd = nb_nxt;
            end
            OP_APPEND: prev_wd = ent_r.tail;
            default:   next_wd = ent_r.head;
          endcase
        end
        state_nxt = S_NBR;
      end

      S_NBR: begin
        if (out_free) begin
          // relink the neighbours to the new node
          if (!empty_r) begin
            case (op_r)
              OP_ADD: begin
                next_we = 1'b1;
                next_wa = NW'(ent_r.cursor);
                next_wd = LW'(new_node);
                prev_we = real_nb;
                prev_wa = NW'(nb_r);
                prev_wd = LW'(new_node);
              end
              OP_INSERT: begin
                prev_we = 1'b1;
                prev_wa = NW'(ent_r.cursor);
                prev_wd = LW'(new_node);
                next_we = real_nb;
                next_wa = NW'(nb_r);
                next_wd = LW'(new_node);
              end
              OP_APPEND: begin
                next_we = real_nb;
                next_wa = NW'(nb_r);
                next_wd = LW'(new_node);
              end
              default: begin
                prev_we = real_nb;
                prev_wa = NW'(nb_r);
                prev_wd = LW'(new_node);
              end
            endcase
          end
          res_nxt               = '0;
          res_nxt.status        = ST_OK;
          res_nxt.node_index    = NODE_W'(new_node);
          res_nxt.item_count    = CNT_W'(upd_r.count);
          res_nxt.cursor_offset = OFF_W'(upd_r.offset);
          res_fire              = 1'b1;
          nodes_used_nxt        = nodes_used_r + 1'b1;
          state_nxt             = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = res_fire | (out_valid_r & ~out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      nodes_used_r <= '0;
      lists_used_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      nodes_used_r <= nodes_used_nxt;
      lists_used_r <= lists_used_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r   <= in_op;
      id_r   <= in_tdata[6:3];
      item_r <= ITEM_BITS'(in_tdata[38:7]);
    end
    ent_r   <= ent_nxt;
    upd_r   <= upd_nxt;
    empty_r <= empty_nxt;
    nb_r    <= nb_nxt;
    if (res_fire) begin
      res_r <= res_nxt;
    end
  end

  lcp_ram #(
    .WIDTH ($bits(list_ent_t)),
    .DEPTH (LIST_COUNT)
  ) u_list_ram (
    .clk     (clk),
    .wr_en   (list_we),
    .wr_addr (list_wa),
    .wr_data (list_wd),
    .rd_en   (list_re),
    .rd_addr (LAW'(in_tdata[6:3])),
    .rd_data (list_q)
  );

  lcp_ram #(
    .WIDTH (LW),
    .DEPTH (NODE_COUNT)
  ) u_next_ram (
    .clk     (clk),
    .wr_en   (next_we),
    .wr_addr (next_wa),
    .wr_data (next_wd),
    .rd_en   (next_re),
    .rd_addr (NW'(list_q.cursor)),
    .rd_data (next_q)
  );

  lcp_ram #(
    .WIDTH (LW),
    .DEPTH (NODE_COUNT)
  ) u_prev_ram (
    .clk     (clk),
    .wr_en   (prev_we),
    .wr_addr (prev_wa),
    .wr_data (prev_wd),
    .rd_en   (prev_re),
    .rd_addr (NW'(list_q.cursor)),
    .rd_data (prev_q)
  );

  lcp_ram #(
    .WIDTH (ITEM_BITS),
    .DEPTH (NODE_COUNT)
  ) u_item_ram (
    .clk     (clk),
    .wr_en   (item_we),
    .wr_addr (new_node),
    .wr_data (item_r),
    .rd_en   (1'b0),
    .rd_addr (new_node),
    .rd_data ()
  );

endmodule

`default_nettype wire
